/* rtl/core/tts_pkg.sv */
// shared types, codes and tag tables for the think tag stream splitter
`default_nettype none
package tts_pkg;

	// request kinds
	typedef enum logic [1:0] {
		KIND_TEXT    = 2'd0,
		KIND_CLEAR   = 2'd1,
		KIND_FOREIGN = 2'd2,
		KIND_UNUSED  = 2'd3
	} tts_kind_t;

	// kind of the newest transcript entry
	typedef enum logic [1:0] {
		ENTRY_NONE     = 2'd0,
		ENTRY_ANSWER   = 2'd1,
		ENTRY_THINKING = 2'd2,
		ENTRY_FOREIGN  = 2'd3
	} tts_entry_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// last index of each tag
	localparam logic [2:0] OPEN_LAST  = 3'd6;
	localparam logic [2:0] CLOSE_LAST = 3'd7;

	localparam logic [7:0] CHAR_LT = 8'h3c;

	// one release job: npre tag prefix bytes, then the data byte when tail is set
	typedef struct packed {
		logic       section;
		logic       marker;
		logic [2:0] npre;
		logic       tail;
		logic [7:0] data;
		logic       start;
	} tts_job_t;

	// byte idx of the tag awaited in the given mode
	function automatic logic [7:0] tag_char(input logic thinking, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		if (thinking) begin
			case (idx)
				3'd0: c = 8'h3c; // <
				3'd1: c = 8'h2f; // /
				3'd2: c = 8'h74; // t
				3'd3: c = 8'h68; // h
				3'd4: c = 8'h69; // i
				3'd5: c = 8'h6e; // n
				3'd6: c = 8'h6b; // k
				default: c = 8'h3e; // >
			endcase
		end else begin
			case (idx)
				3'd0: c = 8'h3c;
				3'd1: c = 8'h74;
				3'd2: c = 8'h68;
				3'd3: c = 8'h69;
				3'd4: c = 8'h6e;
				3'd5: c = 8'h6b;
				3'd6: c = 8'h3e;
				default: c = 8'h00;
			endcase
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/tts_front.sv */
// front end: takes requests, tracks tag match state, issues release jobs
`default_nettype none
module tts_front
	import tts_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic [1:0] req_kind,
	input  wire logic [7:0] req_byte,
	input  wire logic       q_full,
	output logic            req_ready,
	output logic            push,
	output tts_job_t        push_job
);

	logic [2:0] held_q;
	logic       thinking_q;
	tts_entry_t entry_q;

	logic       accept;
	logic [7:0] want;
	logic [2:0] tag_last;
	tts_entry_t mode_entry;

	assign req_ready  = ~q_full;
	assign accept     = req_valid & req_ready;
	assign want       = tag_char(thinking_q, held_q);
	assign tag_last   = thinking_q ? CLOSE_LAST : OPEN_LAST;
	assign mode_entry = thinking_q ? ENTRY_THINKING : ENTRY_ANSWER;

	// held bytes are always a prefix of the awaited tag, so only a count is kept;
	// '<' occurs only at the start of either tag, so a mismatch keeps at most that byte
	always_comb begin
		push              = 1'b0;
		push_job.section  = thinking_q;
		push_job.marker   = 1'b0;
		push_job.npre     = held_q;
		push_job.tail     = 1'b0;
		push_job.data     = req_byte;
		push_job.start    = (entry_q != mode_entry);
		if (accept && tts_kind_t'(req_kind) == KIND_TEXT) begin
			if (req_byte == want) begin
				if (held_q == tag_last) begin
					push             = 1'b1;
					push_job.section = ~thinking_q;
					push_job.marker  = 1'b1;
					push_job.npre    = 3'd0;
					push_job.start   = 1'b1;
				end
			end else if (req_byte == CHAR_LT) begin
				push = 1'b1;
			end else begin
				push          = 1'b1;
				push_job.tail = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= 3'd0;
			thinking_q <= 1'b0;
			entry_q    <= ENTRY_NONE;
		end else if (accept) begin
			unique case (tts_kind_t'(req_kind))
				KIND_TEXT: begin
					if (req_byte == want) begin
						if (held_q == tag_last) begin
							held_q     <= 3'd0;
							thinking_q <= ~thinking_q;
							entry_q    <= thinking_q ? ENTRY_ANSWER : ENTRY_THINKING;
						end else begin
							held_q <= held_q + 3'd1;
						end
					end else begin
						held_q  <= (req_byte == CHAR_LT) ? 3'd1 : 3'd0;
						entry_q <= mode_entry;
					end
				end
				KIND_CLEAR: begin
					held_q     <= 3'd0;
					thinking_q <= 1'b0;
					entry_q    <= ENTRY_NONE;
				end
				KIND_FOREIGN: begin
					entry_q <= ENTRY_FOREIGN;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/core/tts_queue.sv */
// short job queue between front and back end
`default_nettype none
module tts_queue
	import tts_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire tts_job_t push_job,
	input  wire logic     pop,
	output logic          full,
	output logic          not_empty,
	output tts_job_t      head
);

	tts_job_t          mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/tts_back.sv */
// back end: walks each job and emits one result per cycle while the output accepts it
`default_nettype none
module tts_back
	import tts_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     job_valid,
	input  wire tts_job_t job,
	output logic          pop,
	output logic          res_valid,
	input  wire logic     res_ready,
	output logic          res_section,
	output logic          res_has_byte,
	output logic [7:0]    res_text,
	output logic          res_start,
	output logic          res_last
);

	logic [2:0] idx_q;
	logic [3:0] total;
	logic [2:0] last_idx;
	logic       take;

	assign total    = {1'b0, job.npre} + {3'd0, job.tail};
	assign last_idx = job.marker ? 3'd0 : 3'(total - 4'd1);
	assign res_valid = job_valid;
	assign take     = res_valid & res_ready;
	assign pop      = take & (idx_q == last_idx);

	always_comb begin
		res_section  = job.section;
		res_has_byte = ~job.marker;
		res_start    = job.start & (idx_q == 3'd0);
		res_last     = (idx_q == last_idx);
		if (job.marker) begin
			res_text = 8'h00;
		end else if ({1'b0, idx_q} < {1'b0, job.npre}) begin
			res_text = tag_char(job.section, idx_q);
		end else begin
			res_text = job.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
		end else if (take) begin
			idx_q <= pop ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/think_tag_stream_splitter.sv */
// top level of the think tag stream splitter
// a request's job is registered in the job queue; results come from the queue head
// throughput: one request per cycle while the 4-entry job queue has room; the back
// end gives one result per cycle when accepted and pops a job with its last result
// reset: arst_n clears the match state, mode, entry tracking and the job queue
`default_nettype none
module think_tag_stream_splitter
	import tts_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // [7:0] data_byte
	input  wire logic [1:0] s_tuser,  // [1:0] kind
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,  // [7:0] text_out
	output logic [2:0]      m_tuser,  // [0] section, [1] has_byte, [2] starts_entry
	output logic            m_tlast
);

	logic     q_full;
	logic     q_push;
	tts_job_t q_push_job;
	logic     q_pop;
	logic     q_not_empty;
	tts_job_t q_head;

	tts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_kind  (s_tuser),
		.req_byte  (s_tdata),
		.q_full    (q_full),
		.req_ready (s_tready),
		.push      (q_push),
		.push_job  (q_push_job)
	);

	tts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_push_job),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	tts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (q_not_empty),
		.job          (q_head),
		.pop          (q_pop),
		.res_valid    (m_tvalid),
		.res_ready    (m_tready),
		.res_section  (m_tuser[0]),
		.res_has_byte (m_tuser[1]),
		.res_text     (m_tdata),
		.res_start    (m_tuser[2]),
		.res_last     (m_tlast)
	);

endmodule
`default_nettype wire

/* verif/tb_think_tag_stream_splitter.sv */
// self-checking testbench for the think tag stream splitter
`timescale 1ns / 100ps
module tb_think_tag_stream_splitter;
	import tts_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS   = 440;
	localparam logic [55:0] OPEN_TAG  = "<think>";
	localparam logic [63:0] CLOSE_TAG = "</think>";
	localparam logic [63:0] TAG_CHARS = "<>/think";

	typedef struct packed {
		logic       section;
		logic       has_byte;
		logic [7:0] text;
		logic       starts;
		logic       last;
	} splitter_out_t;

	localparam splitter_out_t NO_OUT = '0;

	typedef struct {
		tts_kind_t     kind;
		logic [7:0]    data;
		int            n_typed; // -1: take the predictor's results
		splitter_out_t typed;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	think_tag_stream_splitter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	// predicted block state
	logic [7:0]    held_q [7];
	int            held_n;
	logic          thinking;
	tts_entry_t    newest_entry;
	splitter_out_t step_res [8];
	splitter_out_t pending_out [$];
	splitter_out_t head;

	int errs = 0;
	int n_text = 0, n_clear = 0, n_foreign = 0, n_checked = 0, n_markers = 0;
	int longest_burst = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	int calm_left = 0;

	dir_row_t dir_rows [0:24] = '{
		'{KIND_TEXT, "a", 1, '{1'b0, 1'b1, 8'h61, 1'b1, 1'b1}},
		'{KIND_TEXT, 8'h00, -1, NO_OUT},
		'{KIND_TEXT, 8'hff, -1, NO_OUT},
		'{KIND_TEXT, "<", 0, NO_OUT},
		'{KIND_TEXT, "t", 0, NO_OUT},
		'{KIND_TEXT, "h", 0, NO_OUT},
		'{KIND_TEXT, "i", 0, NO_OUT},
		'{KIND_TEXT, "n", 0, NO_OUT},
		'{KIND_TEXT, "k", 0, NO_OUT},
		'{KIND_TEXT, ">", 1, '{1'b1, 1'b0, 8'h00, 1'b1, 1'b1}},
		'{KIND_TEXT, "x", -1, NO_OUT},
		'{KIND_TEXT, "<", 0, NO_OUT},
		'{KIND_TEXT, "/", 0, NO_OUT},
		'{KIND_TEXT, "t", 0, NO_OUT},
		'{KIND_TEXT, "h", 0, NO_OUT},
		'{KIND_TEXT, "i", 0, NO_OUT},
		'{KIND_TEXT, "n", 0, NO_OUT},
		'{KIND_TEXT, "k", 0, NO_OUT},
		// seven held bytes plus a mismatch: widest release
		'{KIND_TEXT, "Z", -1, NO_OUT},
		'{KIND_FOREIGN, 8'ha5, 0, NO_OUT},
		'{KIND_TEXT, "y", -1, NO_OUT},
		'{KIND_UNUSED, 8'h3c, 0, NO_OUT},
		'{KIND_TEXT, "<", 0, NO_OUT},
		'{KIND_CLEAR, 8'h5a, 0, NO_OUT},
		'{KIND_TEXT, "b", 1, '{1'b0, 1'b1, 8'h62, 1'b1, 1'b1}}
	};

	function automatic logic [7:0] tag_at(input logic th, input int idx);
		return th ? CLOSE_TAG[8*(7-idx) +: 8] : OPEN_TAG[8*(6-idx) +: 8];
	endfunction

	function automatic void split_reset();
		for (int i = 0; i < 7; i++)
			held_q[i] = 8'h00;
		held_n = 0;
		thinking = 1'b0;
		newest_entry = ENTRY_NONE;
	endfunction

	// queue one result for the checker
	function automatic void expect_res(input splitter_out_t r);
		pending_out.insert(pending_out.size(), r);
	endfunction

	// returns the number of results, written to step_res
	function automatic int split_step(input tts_kind_t k, input logic [7:0] b);
		logic [7:0] seq [8];
		int len, tlen, keep, rel, n, i;
		bit same;
		tts_entry_t mode_e;
		if (k == KIND_CLEAR) begin
			split_reset();
			return 0;
		end
		if (k == KIND_FOREIGN) begin
			newest_entry = ENTRY_FOREIGN;
			return 0;
		end
		if (k != KIND_TEXT)
			return 0;
		tlen = thinking ? 8 : 7;
		for (i = 0; i < held_n; i++)
			seq[i] = held_q[i];
		seq[held_n] = b;
		len = held_n + 1;
		if (len == tlen) begin
			same = 1'b1;
			for (i = 0; i < len; i++)
				if (seq[i] != tag_at(thinking, i))
					same = 1'b0;
			if (same) begin
				held_n = 0;
				thinking = ~thinking;
				newest_entry = thinking ? ENTRY_THINKING : ENTRY_ANSWER;
				step_res[0] = '{thinking, 1'b0, 8'h00, 1'b1, 1'b1};
				return 1;
			end
		end
		// keep the longest tail that still opens the awaited tag
		keep = 0;
		for (n = (len < tlen - 1 ? len : tlen - 1); n > 0 && keep == 0; n--) begin
			same = 1'b1;
			for (i = 0; i < n; i++)
				if (seq[len - n + i] != tag_at(thinking, i))
					same = 1'b0;
			if (same)
				keep = n;
		end
		rel = len - keep;
		mode_e = thinking ? ENTRY_THINKING : ENTRY_ANSWER;
		for (i = 0; i < rel; i++)
			step_res[i] = '{thinking, 1'b1, seq[i],
				(i == 0 && newest_entry != mode_e), (i + 1 == rel)};
		for (i = 0; i < keep; i++)
			held_q[i] = seq[rel + i];
		held_n = keep;
		if (rel > 0)
			newest_entry = mode_e;
		return rel;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_left > 0 || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 255));
		return TAG_CHARS[8*$urandom_range(0, 7) +: 8];
	endfunction

	task automatic send_req(input tts_kind_t k, input logic [7:0] d, input int n_typed,
			input splitter_out_t typed);
		int gap, n, i;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		n = split_step(k, d);
		if (n_typed >= 0) begin
			if (n_typed == 1)
				expect_res(typed);
		end else begin
			for (i = 0; i < n; i++)
				expect_res(step_res[i]);
		end
		if (n > longest_burst)
			longest_burst = n;
		case (k)
			KIND_TEXT:    n_text++;
			KIND_CLEAR:   n_clear++;
			KIND_FOREIGN: n_foreign++;
			default: ;
		endcase
	endtask

	task automatic send_text(input logic [7:0] d);
		send_req(KIND_TEXT, d, -1, NO_OUT);
	endtask

	// hold the sender off until every predicted result is out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_out.size() != 0);
	endtask

	// result checker and backpressure
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_checked++;
			if (pending_out.size() == 0) begin
				$error("unexpected result: text_out %h tuser %b last %b",
					m_tdata, m_tuser, m_tlast);
				errs++;
			end else begin
				head = pending_out.pop_front();
				if (!head.has_byte)
					n_markers++;
				if (m_tuser[0] !== head.section) begin
					$error("section: expected %0d, got %0d", head.section, m_tuser[0]);
					errs++;
				end
				if (m_tuser[1] !== head.has_byte) begin
					$error("has_byte: expected %0d, got %0d", head.has_byte, m_tuser[1]);
					errs++;
				end
				if (m_tdata !== head.text) begin
					$error("text_out: expected %h, got %h", head.text, m_tdata);
					errs++;
				end
				if (m_tuser[2] !== head.starts) begin
					$error("starts_entry: expected %0d, got %0d", head.starts, m_tuser[2]);
					errs++;
				end
				if (m_tlast !== head.last) begin
					$error("last: expected %0d, got %0d", head.last, m_tlast);
					errs++;
				end
			end
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 99) < 25)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("FAIL think_tag_stream_splitter");
					$finish;
				end
			end
		end
	end

	initial begin
		int items, r, tlen, cut, i;
		logic th;
		bit drained;
		items = 0;
		drained = 1'b0;
		split_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_req(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].n_typed, dir_rows[i].typed);
		drain();

		while (items < RANDOM_ITEMS) begin
			if (calm_left > 0)
				calm_left--;
			else if ($urandom_range(0, 9) == 0)
				calm_left = $urandom_range(5, 20);
			if (!drained && items >= RANDOM_ITEMS / 2) begin
				drain();
				drained = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 45) begin
				// mostly the awaited tag, sometimes the other one, whole or cut short
				th = ($urandom_range(0, 9) == 0) ? ~thinking : thinking;
				tlen = th ? 8 : 7;
				cut = ($urandom_range(0, 1) == 0) ? tlen : $urandom_range(1, tlen - 1);
				for (i = 0; i < cut; i++)
					send_text(tag_at(th, i));
				items += cut;
				if (cut < tlen) begin
					send_text(pick_byte());
					items++;
				end
			end else if (r < 85) begin
				cut = $urandom_range(1, 6);
				for (i = 0; i < cut; i++)
					send_text(pick_byte());
				items += cut;
			end else if (r < 91) begin
				send_req(KIND_FOREIGN, 8'($urandom_range(0, 255)), -1, NO_OUT);
				items++;
			end else if (r < 95) begin
				send_req(KIND_CLEAR, 8'($urandom_range(0, 255)), -1, NO_OUT);
				items++;
			end else begin
				send_req(KIND_UNUSED, 8'($urandom_range(0, 255)), -1, NO_OUT);
			end
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_out.size() != 0);
		repeat (16) @(posedge clk);

		$display("requests: %0d text bytes, %0d clears, %0d foreign marks; %0d results checked",
			n_text, n_clear, n_foreign, n_checked);
		$display("mode switch markers: %0d, widest release: %0d bytes", n_markers, longest_burst);
		if (errs == 0 && pending_out.size() == 0)
			$display("PASS think_tag_stream_splitter");
		else
			$display("FAIL think_tag_stream_splitter");
		$finish;
	end

endmodule

/* files.f */
rtl/core/tts_pkg.sv
rtl/core/tts_front.sv
rtl/core/tts_queue.sv
rtl/core/tts_back.sv
rtl/core/think_tag_stream_splitter.sv
verif/tb_think_tag_stream_splitter.sv
